FILE: src/bro_pkg.sv
package bro_pkg;

  // Slot store geometry
  localparam int BLOCK_DEPTH = 64;
  localparam int IDX_W       = $clog2(BLOCK_DEPTH);
  localparam int CNT_W       = 7;

  // Field widths of the input and result words
  localparam int REQ_W   = 2;
  localparam int SEQ_W   = 16;
  localparam int TAG_W   = 16;
  localparam int LEN_W   = 16;
  localparam int STAT_W  = 3;
  localparam int OSEQ_W  = 6;
  localparam int PHASE_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_START = 2'd0,
    REQ_BLOCK = 2'd1,
    REQ_END   = 2'd2,
    REQ_BAD   = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DELIVERED = 3'd0,
    ST_BUFFERED  = 3'd1,
    ST_STARTED   = 3'd2,
    ST_ERROR     = 3'd3,
    ST_STALE     = 3'd4
  } status_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_STARTED = 2'd0,
    PH_XFER    = 2'd1,
    PH_END     = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  // One result word as held in the output register
  typedef struct packed {
    status_e             status;
    logic [OSEQ_W-1:0]   out_seq;
    logic [TAG_W-1:0]    out_tag;
    logic [LEN_W-1:0]    out_len;
    phase_e              phase;
    logic [CNT_W-1:0]    received_count;
    logic                last;
    logic                done_res;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic eval_load;
    logic drain_read;
    logic drain_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic eval_more;
    logic drain_more;
  } sts_t;

endpackage

FILE: src/bro_if.sv
// Request channel: one word per input item.
interface bro_req_if;
  logic                        valid;
  logic                        ready;
  logic [bro_pkg::REQ_W-1:0]   req_type;
  logic [bro_pkg::CNT_W-1:0]   block_count;
  logic [bro_pkg::SEQ_W-1:0]   block_seq;
  logic [bro_pkg::TAG_W-1:0]   block_tag;
  logic [bro_pkg::LEN_W-1:0]   block_len;

  modport source (output valid, req_type, block_count, block_seq, block_tag, block_len,
                  input ready);
  modport sink   (input valid, req_type, block_count, block_seq, block_tag, block_len,
                  output ready);
endinterface

// Result channel: one word per result.
interface bro_res_if;
  logic                          valid;
  logic                          ready;
  logic [bro_pkg::STAT_W-1:0]    status;
  logic [bro_pkg::OSEQ_W-1:0]    out_seq;
  logic [bro_pkg::TAG_W-1:0]     out_tag;
  logic [bro_pkg::LEN_W-1:0]     out_len;
  logic [bro_pkg::PHASE_W-1:0]   phase;
  logic [bro_pkg::CNT_W-1:0]     received_count;
  logic                          last;
  logic                          done_res;

  modport source (output valid, status, out_seq, out_tag, out_len, phase, received_count,
                  last, done_res, input ready);
  modport sink   (input valid, status, out_seq, out_tag, out_len, phase, received_count,
                  last, done_res, output ready);
endinterface

FILE: src/bro_ctrl.sv
module bro_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bro_pkg::sts_t sts_i,
  output bro_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_DRAIN
  } state_e;

  state_e state_q;

  // Command decode from the current state
  always_comb begin
    cmd_o            = '0;
    in_ready_o       = (state_q == S_IDLE);
    cmd_o.capture    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.eval_load  = (state_q == S_EVAL) && sts_i.out_free;
    cmd_o.drain_read = (state_q == S_READ);
    cmd_o.drain_load = (state_q == S_DRAIN) && sts_i.out_free;
  end

  // State register: evaluate, then alternate slot read and delivery while the run lasts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (sts_i.out_free) begin
            state_q <= sts_i.eval_more ? S_READ : S_IDLE;
          end
        end
        S_READ: begin
          state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (sts_i.out_free) begin
            state_q <= sts_i.drain_more ? S_READ : S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/bro_datapath.sv
module bro_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bro_pkg::cmd_t                 cmd_i,
  output bro_pkg::sts_t                 sts_o,
  input  logic [bro_pkg::REQ_W-1:0]     req_type_i,
  input  logic [bro_pkg::CNT_W-1:0]     block_count_i,
  input  logic [bro_pkg::SEQ_W-1:0]     block_seq_i,
  input  logic [bro_pkg::TAG_W-1:0]     block_tag_i,
  input  logic [bro_pkg::LEN_W-1:0]     block_len_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output bro_pkg::res_t                 res_o
);

  localparam int MEM_W = bro_pkg::TAG_W + bro_pkg::LEN_W;

  // Captured input word
  bro_pkg::req_e                 item_req_q;
  logic [bro_pkg::CNT_W-1:0]     item_cnt_q;
  logic [bro_pkg::SEQ_W-1:0]     item_seq_q;
  logic [bro_pkg::TAG_W-1:0]     item_tag_q;
  logic [bro_pkg::LEN_W-1:0]     item_len_q;

  // Transfer state
  logic [bro_pkg::BLOCK_DEPTH-1:0] valid_q, valid_d;
  logic [bro_pkg::CNT_W-1:0]       expected_q, expected_d;
  logic [bro_pkg::CNT_W-1:0]       total_q, total_d;
  logic [bro_pkg::CNT_W-1:0]       acc_q, acc_d;
  logic                            open_q, open_d;
  bro_pkg::phase_e                 phase_q, phase_d;

  // Output register
  logic                            out_valid_q, out_valid_d;
  bro_pkg::res_t                   res_q, res_d;

  // Slot payload store
  logic [MEM_W-1:0]                mem_q [bro_pkg::BLOCK_DEPTH];
  logic [MEM_W-1:0]                rd_q;
  logic                            mem_we;

  // Evaluation terms
  logic                            cnt_bad;
  logic                            is_err;
  logic                            is_stale;
  logic                            is_hit;
  logic                            is_buf;
  logic [bro_pkg::IDX_W-1:0]       seq_idx;
  logic [bro_pkg::CNT_W-1:0]       exp_inc;
  logic [bro_pkg::CNT_W-1:0]       acc_inc;
  logic                            hit_close;
  logic                            eval_more;
  logic                            drain_more;
  bro_pkg::phase_e                 blk_phase;

  // Classify the captured word against the transfer state
  always_comb begin
    cnt_bad   = (item_cnt_q == '0) ||
                (item_cnt_q > bro_pkg::CNT_W'(bro_pkg::BLOCK_DEPTH));
    is_err    = (item_req_q == bro_pkg::REQ_BAD) || !open_q ||
                (item_seq_q >= bro_pkg::SEQ_W'(total_q));
    is_stale  = !is_err && (item_seq_q < bro_pkg::SEQ_W'(expected_q));
    is_hit    = !is_err && (item_seq_q == bro_pkg::SEQ_W'(expected_q));
    is_buf    = !is_err && !is_stale && !is_hit;
    seq_idx   = item_seq_q[bro_pkg::IDX_W-1:0];
    exp_inc   = expected_q + bro_pkg::CNT_W'(1);
    acc_inc   = acc_q + bro_pkg::CNT_W'(1);
    // Every slot between the expected number and the count is held exactly when the
    // distinct count reaches the block count, so the close is known before the drain.
    hit_close = (acc_inc == total_q);
    blk_phase = (item_req_q == bro_pkg::REQ_END) ? bro_pkg::PH_END : bro_pkg::PH_XFER;
    // The slot after the one just delivered continues the run if it is held.
    eval_more  = (exp_inc < total_q) && valid_q[exp_inc[bro_pkg::IDX_W-1:0]];
    drain_more = eval_more;
  end

  assign sts_o.out_free   = !out_valid_q || res_ready_i;
  assign sts_o.eval_more  = (item_req_q != bro_pkg::REQ_START) && is_hit && eval_more;
  assign sts_o.drain_more = drain_more;
  assign mem_we           = cmd_i.eval_load && (item_req_q != bro_pkg::REQ_START) && is_buf;

  // Next state of the transfer and of the output register
  always_comb begin
    valid_d     = valid_q;
    expected_d  = expected_q;
    total_d     = total_q;
    acc_d       = acc_q;
    open_d      = open_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.eval_load) begin
      out_valid_d          = 1'b1;
      res_d                = '0;
      res_d.status         = bro_pkg::ST_ERROR;
      res_d.phase          = phase_q;
      res_d.received_count = acc_q;
      res_d.last           = 1'b1;
      if (item_req_q == bro_pkg::REQ_START) begin
        if (!cnt_bad) begin
          valid_d              = '0;
          expected_d           = '0;
          total_d              = item_cnt_q;
          acc_d                = '0;
          open_d               = 1'b1;
          phase_d              = bro_pkg::PH_STARTED;
          res_d.status         = bro_pkg::ST_STARTED;
          res_d.phase          = bro_pkg::PH_STARTED;
          res_d.received_count = '0;
        end
      end else if (is_stale) begin
        res_d.status  = bro_pkg::ST_STALE;
        res_d.out_seq = item_seq_q[bro_pkg::OSEQ_W-1:0];
      end else if (is_hit) begin
        // Deliver at once; the run of held slots follows.
        acc_d                = acc_inc;
        expected_d           = exp_inc;
        phase_d              = hit_close ? bro_pkg::PH_DONE : blk_phase;
        open_d               = !hit_close;
        res_d.status         = bro_pkg::ST_DELIVERED;
        res_d.out_seq        = item_seq_q[bro_pkg::OSEQ_W-1:0];
        res_d.out_tag        = item_tag_q;
        res_d.out_len        = item_len_q;
        res_d.phase          = hit_close ? bro_pkg::PH_DONE : blk_phase;
        res_d.received_count = acc_inc;
        res_d.last           = !eval_more;
        res_d.done_res       = hit_close && !eval_more;
      end else if (is_buf) begin
        // Hold the block in its slot; a repeat is not counted again.
        valid_d[seq_idx]     = 1'b1;
        acc_d                = valid_q[seq_idx] ? acc_q : acc_inc;
        phase_d              = blk_phase;
        res_d.status         = bro_pkg::ST_BUFFERED;
        res_d.out_seq        = item_seq_q[bro_pkg::OSEQ_W-1:0];
        res_d.phase          = blk_phase;
        res_d.received_count = valid_q[seq_idx] ? acc_q : acc_inc;
      end
    end

    if (cmd_i.drain_load) begin
      // Deliver the held slot at the expected number and release it.
      out_valid_d          = 1'b1;
      valid_d[expected_q[bro_pkg::IDX_W-1:0]] = 1'b0;
      expected_d           = exp_inc;
      res_d.status         = bro_pkg::ST_DELIVERED;
      res_d.out_seq        = expected_q[bro_pkg::OSEQ_W-1:0];
      res_d.out_tag        = rd_q[MEM_W-1:bro_pkg::LEN_W];
      res_d.out_len        = rd_q[bro_pkg::LEN_W-1:0];
      res_d.phase          = phase_q;
      res_d.received_count = acc_q;
      res_d.last           = !drain_more;
      res_d.done_res       = !drain_more && (phase_q == bro_pkg::PH_DONE);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      expected_q  <= '0;
      total_q     <= '0;
      acc_q       <= '0;
      open_q      <= 1'b0;
      phase_q     <= bro_pkg::PH_STARTED;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      expected_q  <= expected_d;
      total_q     <= total_d;
      acc_q       <= acc_d;
      open_q      <= open_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.capture) begin
      item_req_q <= bro_pkg::req_e'(req_type_i);
      item_cnt_q <= block_count_i;
      item_seq_q <= block_seq_i;
      item_tag_q <= block_tag_i;
      item_len_q <= block_len_i;
    end
  end

  // Slot store: one write port for buffering, one registered read for the drain.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[seq_idx] <= {item_tag_q, item_len_q};
    end
    if (cmd_i.drain_read) begin
      rd_q <= mem_q[expected_q[bro_pkg::IDX_W-1:0]];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

FILE: src/block_reorder_buffer.sv
// Flow: an input word is captured while idle and evaluated into the output register once
// that register is free; each further block released from the slot store goes through its
// single registered read port and is then loaded into the output register. A new input
// word is accepted only after the evaluation and any release run of the last one have ended.
// Reset: no transfer open, all slot valid bits cleared at once, counters and phase at
// zero; the slot payload store is not cleared and is read only where its slot is valid.
module block_reorder_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  bro_req_if.sink    req_i,
  bro_res_if.source  res_o
);

  bro_pkg::cmd_t cmd;
  bro_pkg::sts_t sts;
  bro_pkg::res_t res;
  logic          in_ready;
  logic          res_valid;

  // Sequencing of evaluation and drain
  bro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot store, transfer state and output register
  bro_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .block_count_i (req_i.block_count),
    .block_seq_i   (req_i.block_seq),
    .block_tag_i   (req_i.block_tag),
    .block_len_i   (req_i.block_len),
    .res_ready_i   (res_o.ready),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Channel wiring
  assign req_i.ready          = in_ready;
  assign res_o.valid          = res_valid;
  assign res_o.status         = res.status;
  assign res_o.out_seq        = res.out_seq;
  assign res_o.out_tag        = res.out_tag;
  assign res_o.out_len        = res.out_len;
  assign res_o.phase          = res.phase;
  assign res_o.received_count = res.received_count;
  assign res_o.last           = res.last;
  assign res_o.done_res       = res.done_res;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_WORDS = 450;
  localparam int MAX_GAP      = 13;
  localparam int TAIL_CYCLES  = 20;

  // One request word as the sender hands it over.
  typedef struct packed {
    logic [bro_pkg::REQ_W-1:0] req_type;
    logic [bro_pkg::CNT_W-1:0] block_count;
    logic [bro_pkg::SEQ_W-1:0] block_seq;
    logic [bro_pkg::TAG_W-1:0] block_tag;
    logic [bro_pkg::LEN_W-1:0] block_len;
  } req_word_t;

  // Tracks the reassembly state and holds the result words still owed by the block.
  class reorder_scoreboard;
    bit                        slot_valid [bro_pkg::BLOCK_DEPTH];
    logic [bro_pkg::TAG_W-1:0] slot_tag [bro_pkg::BLOCK_DEPTH];
    logic [bro_pkg::LEN_W-1:0] slot_len [bro_pkg::BLOCK_DEPTH];
    int unsigned               next_seq     = 0;
    int unsigned               total_blocks = 0;
    logic [bro_pkg::CNT_W-1:0] accepted     = '0;
    bit                        xfer_open    = 1'b0;
    bro_pkg::phase_e           phase_now    = bro_pkg::PH_STARTED;
    bro_pkg::res_t             owed_words[$];
    bro_pkg::res_t             fresh[$];
    int                        failures     = 0;

    // Queues one result word of the current request; the trailing fields come later.
    function void emit(bro_pkg::status_e st, int unsigned seq,
                       logic [bro_pkg::TAG_W-1:0] tag, logic [bro_pkg::LEN_W-1:0] len);
      bro_pkg::res_t r;
      r         = '0;
      r.status  = st;
      r.out_seq = seq[bro_pkg::OSEQ_W-1:0];
      r.out_tag = tag;
      r.out_len = len;
      fresh.push_back(r);
    endfunction

    // Works out every result word that an accepted request word causes.
    function void note_request(req_word_t w);
      int unsigned seq;
      int unsigned cnt;
      bit          closed;
      seq    = 32'(w.block_seq);
      cnt    = 32'(w.block_count);
      closed = 1'b0;
      fresh.delete();
      if (w.req_type == bro_pkg::REQ_START) begin
        if (cnt == 0 || cnt > bro_pkg::BLOCK_DEPTH) begin
          emit(bro_pkg::ST_ERROR, 0, '0, '0);
        end else begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
          next_seq     = 0;
          total_blocks = cnt;
          accepted     = '0;
          xfer_open    = 1'b1;
          phase_now    = bro_pkg::PH_STARTED;
          emit(bro_pkg::ST_STARTED, 0, '0, '0);
        end
      end else if (w.req_type == bro_pkg::REQ_BAD || !xfer_open || seq >= total_blocks) begin
        emit(bro_pkg::ST_ERROR, 0, '0, '0);
      end else if (seq < next_seq) begin
        emit(bro_pkg::ST_STALE, seq, '0, '0);
      end else begin
        if (seq == next_seq) begin
          // In-order block: release it, then every stored block that follows without a gap.
          emit(bro_pkg::ST_DELIVERED, seq, w.block_tag, w.block_len);
          accepted++;
          next_seq++;
          while (next_seq < total_blocks && slot_valid[next_seq]) begin
            emit(bro_pkg::ST_DELIVERED, next_seq, slot_tag[next_seq], slot_len[next_seq]);
            slot_valid[next_seq] = 1'b0;
            next_seq++;
          end
        end else begin
          // Early block: park it; a repeat overwrites the copy without counting again.
          if (!slot_valid[seq]) accepted++;
          slot_valid[seq] = 1'b1;
          slot_tag[seq]   = w.block_tag;
          slot_len[seq]   = w.block_len;
          emit(bro_pkg::ST_BUFFERED, seq, '0, '0);
        end
        phase_now = (w.req_type == bro_pkg::REQ_END) ? bro_pkg::PH_END : bro_pkg::PH_XFER;
        if (next_seq == total_blocks) begin
          phase_now = bro_pkg::PH_DONE;
          xfer_open = 1'b0;
          closed    = 1'b1;
        end
      end
      foreach (fresh[k]) begin
        fresh[k].phase          = phase_now;
        fresh[k].received_count = accepted;
        fresh[k].last           = (k == fresh.size() - 1);
        fresh[k].done_res       = fresh[k].last && closed;
        owed_words.push_back(fresh[k]);
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Compares one accepted result word with the oldest one owed.
    function void check_result(bro_pkg::res_t got);
      bro_pkg::res_t want;
      if (owed_words.size() == 0) begin
        $error("result word with nothing owed: status %0d, out_seq %0d",
               got.status, got.out_seq);
        failures++;
        return;
      end
      want = owed_words.pop_front();
      compare("status", 32'(want.status), 32'(got.status));
      compare("out_seq", 32'(want.out_seq), 32'(got.out_seq));
      compare("out_tag", 32'(want.out_tag), 32'(got.out_tag));
      compare("out_len", 32'(want.out_len), 32'(got.out_len));
      compare("phase", 32'(want.phase), 32'(got.phase));
      compare("received_count", 32'(want.received_count), 32'(got.received_count));
      compare("last", 32'(want.last), 32'(got.last));
      compare("done_res", 32'(want.done_res), 32'(got.done_res));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  int   words_sent = 0;

  reorder_scoreboard sb = new;

  bro_req_if req_if ();
  bro_res_if res_if ();

  block_reorder_buffer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .res_o  (res_if.source)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hands one request word over, after a random gap, and waits until it is taken.
  task automatic send_word(input bro_pkg::req_e kind, input logic [31:0] cnt,
                           input logic [31:0] seq, input logic [31:0] tag,
                           input logic [31:0] len);
    int        gap;
    req_word_t w;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    w.req_type    = kind;
    w.block_count = bro_pkg::CNT_W'(cnt);
    w.block_seq   = bro_pkg::SEQ_W'(seq);
    w.block_tag   = bro_pkg::TAG_W'(tag);
    w.block_len   = bro_pkg::LEN_W'(len);
    req_if.valid       <= 1'b1;
    req_if.req_type    <= w.req_type;
    req_if.block_count <= w.block_count;
    req_if.block_seq   <= w.block_seq;
    req_if.block_tag   <= w.block_tag;
    req_if.block_len   <= w.block_len;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(w);
    words_sent++;
  endtask

  // Holds the sender off until every owed result word has come back.
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.owed_words.size() != 0);
  endtask

  // A data block, mostly plain, sometimes flagged as the end block.
  task automatic send_block(input int seq, input bit final_one);
    bro_pkg::req_e kind;
    kind = ((final_one && $urandom_range(0, 1)) || $urandom_range(0, 7) == 0) ?
           bro_pkg::REQ_END : bro_pkg::REQ_BLOCK;
    send_word(kind, $urandom(), seq, $urandom(), $urandom());
  endtask

  // Disturbances inside a transfer: repeats, out-of-range numbers, bad requests, bad starts.
  task automatic send_noise(input int n);
    case ($urandom_range(0, 3))
      0: send_block($urandom_range(0, n - 1), 1'b0);
      1: send_word(bro_pkg::REQ_BLOCK, $urandom(), $urandom_range(n, 65535), $urandom(),
                   $urandom());
      2: send_word(bro_pkg::REQ_BAD, $urandom(), $urandom(), $urandom(), $urandom());
      default: send_word(bro_pkg::REQ_START, $urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
                         $urandom(), $urandom(), $urandom());
    endcase
  endtask

  // One transfer: a start word, then its blocks, often shuffled and sometimes cut short, with some noise.
  task automatic run_transfer(input bit full_drain);
    int n;
    int pick;
    int stop_at;
    int j;
    int tmp;
    int order[$];
    if (!full_drain && $urandom_range(0, 9) == 0) hold_until_drained();
    pick = $urandom_range(0, 19);
    if (full_drain)     n = bro_pkg::BLOCK_DEPTH;
    else if (pick < 15) n = $urandom_range(1, 8);
    else if (pick < 19) n = $urandom_range(9, 24);
    else                n = $urandom_range(25, bro_pkg::BLOCK_DEPTH);
    send_word(bro_pkg::REQ_START, n, $urandom(), $urandom(), $urandom());
    for (int i = 0; i < n; i++) order.push_back(i);
    if (full_drain) begin
      // Block zero last, so that its arrival releases the whole store in one run.
      order.push_back(order.pop_front());
    end else if ($urandom_range(0, 4) != 0) begin
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    stop_at = (!full_drain && $urandom_range(0, 11) == 0) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 5) == 0) send_noise(n);
      send_block(order[i], i == n - 1);
    end
    // Now and then a block after the transfer has closed or been left.
    if ($urandom_range(0, 3) == 0) send_block($urandom_range(0, n), 1'b0);
  endtask

  // Reset, directed words, random transfers, then the verdict.
  initial begin : stimulus
    int base;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= bro_pkg::REQ_START;
    req_if.block_count <= '0;
    req_if.block_seq   <= '0;
    req_if.block_tag   <= '0;
    req_if.block_len   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No transfer open yet, unknown request type, and starts with bad counts.
    send_word(bro_pkg::REQ_BLOCK, 0, 0, 'h1234, 'h0042);
    send_word(bro_pkg::REQ_BAD, 'h7F, 'hFFFF, 'hFFFF, 'hFFFF);
    send_word(bro_pkg::REQ_START, 0, 0, 0, 0);
    send_word(bro_pkg::REQ_START, bro_pkg::BLOCK_DEPTH + 1, 0, 0, 0);
    send_word(bro_pkg::REQ_START, 'h7F, 0, 0, 0);
    // Single-block transfer that closes at once, then a block after the close.
    send_word(bro_pkg::REQ_START, 1, 0, 0, 0);
    send_word(bro_pkg::REQ_END, 0, 0, 'hFFFF, 'hFFFF);
    send_word(bro_pkg::REQ_BLOCK, 0, 0, 'h0001, 'h0001);
    // Early blocks, a repeat that replaces its copy, range errors, then the drain.
    send_word(bro_pkg::REQ_START, 4, 0, 0, 0);
    send_word(bro_pkg::REQ_BLOCK, 0, 2, 'h0001, 'h0001);
    send_word(bro_pkg::REQ_BLOCK, 0, 2, 'hAAAA, 'h5555);
    send_word(bro_pkg::REQ_BLOCK, 0, 3, 'h5555, 'hAAAA);
    send_word(bro_pkg::REQ_BLOCK, 0, 4, 'h0BAD, 'h0BAD);
    send_word(bro_pkg::REQ_BLOCK, 0, 'hFFFF, 'h0BAD, 'h0BAD);
    send_word(bro_pkg::REQ_BAD, 0, 1, 0, 0);
    send_word(bro_pkg::REQ_BLOCK, 0, 0, 'h0000, 'h0000);
    send_word(bro_pkg::REQ_END, 0, 1, 'h8001, 'h7FFE);
    // A stale repeat, then a start that abandons a running transfer.
    send_word(bro_pkg::REQ_START, 3, 0, 0, 0);
    send_word(bro_pkg::REQ_BLOCK, 0, 0, 'h00FF, 'hFF00);
    send_word(bro_pkg::REQ_BLOCK, 0, 0, 'hFF00, 'h00FF);
    send_word(bro_pkg::REQ_START, bro_pkg::BLOCK_DEPTH, 0, 0, 0);
    send_word(bro_pkg::REQ_BLOCK, 0, bro_pkg::BLOCK_DEPTH - 1, 'hC3C3, 'h3C3C);
    send_word(bro_pkg::REQ_END, 0, bro_pkg::BLOCK_DEPTH - 2, 'h0F0F, 'hF0F0);
    send_word(bro_pkg::REQ_BLOCK, 0, 0, 'h7777, 'h8888);
    hold_until_drained();

    base = words_sent;
    run_transfer(1'b1);
    while (words_sent - base < RANDOM_WORDS) run_transfer(1'b0);

    // Let every owed word come back, then watch for strays.
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.owed_words.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.owed_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stalls before each word, with stretches of none.
  initial begin : result_sink
    int            stall;
    bro_pkg::res_t got;
    res_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got = {res_if.status, res_if.out_seq, res_if.out_tag, res_if.out_len,
             res_if.phase, res_if.received_count, res_if.last, res_if.done_res};
      sb.check_result(got);
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
